// ===== hw/rtl/smn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smn_pkg
// Shared types, constants and Sobel kernel tables for the edge magnitude block.
// ----------------------------------------------------------------------------
package smn_pkg;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int DEF_PIXEL_BITS = 8;

   localparam int PIX_IN_W   = 8;
   localparam int EDGE_W     = 8;
   localparam int CSR_DATA_W = 9;
   localparam int CSR_IDX_W  = 1;
   localparam int DIM_RESET  = 256;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [3:0] K_LAST = 4'd8;

   typedef struct packed {
      logic                command;
      logic [PIX_IN_W-1:0] pixel;
   } req_type;

   typedef struct packed {
      logic [EDGE_W-1:0] edge_value;
      logic              ready_res;
      logic              last;
   } rsp_type;

   // window position k = 3*row + col
   function automatic logic [1:0] k_row(input logic [3:0] k);
      logic [1:0] r;
      unique case (k)
         4'd0, 4'd1, 4'd2: r = 2'd0;
         4'd3, 4'd4, 4'd5: r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] k_col(input logic [3:0] k);
      logic [1:0] c;
      unique case (k)
         4'd0, 4'd3, 4'd6: c = 2'd0;
         4'd1, 4'd4, 4'd7: c = 2'd1;
         default:          c = 2'd2;
      endcase
      return c;
   endfunction

   function automatic logic signed [2:0] k_wx(input logic [3:0] k);
      logic signed [2:0] w;
      unique case (k)
         4'd0, 4'd6: w = -3'sd1;
         4'd3:       w = -3'sd2;
         4'd2, 4'd8: w = 3'sd1;
         4'd5:       w = 3'sd2;
         default:    w = 3'sd0;
      endcase
      return w;
   endfunction

   function automatic logic signed [2:0] k_wy(input logic [3:0] k);
      logic signed [2:0] w;
      unique case (k)
         4'd0, 4'd2: w = -3'sd1;
         4'd1:       w = -3'sd2;
         4'd6, 4'd8: w = 3'sd1;
         4'd7:       w = 3'sd2;
         default:    w = 3'sd0;
      endcase
      return w;
   endfunction

endpackage

// ===== hw/rtl/smn_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smn_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module smn_ram #(
   parameter int DEPTH  = 65536,
   parameter int DATA_W = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [DATA_W-1:0]        wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [DATA_W-1:0]        rdata
);
   import smn_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/smn_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smn_isqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module smn_isqrt #(
   parameter int ROOT_W = 11
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [2*ROOT_W-1:0]   value,
   output logic                  done,
   output logic [ROOT_W-1:0]     root
);
   import smn_pkg::*;

   localparam int RW  = ROOT_W + 3;
   localparam int CW  = $clog2(ROOT_W + 1);

   logic [2*ROOT_W-1:0] val_ff;
   logic [RW-1:0]       rem_ff;
   logic [ROOT_W-1:0]   root_ff;
   logic [CW-1:0]       cnt_ff;
   logic                busy_ff;
   logic                done_ff;
   logic [RW-1:0]       rem_sh;
   logic [RW-1:0]       trial;

   assign rem_sh = {rem_ff[RW-3:0], val_ff[2*ROOT_W-1 -: 2]};
   assign trial  = RW'({root_ff, 2'b01});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            val_ff  <= value;
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= CW'(ROOT_W);
         end else if (busy_ff) begin
            val_ff <= val_ff << 2;
            if (rem_sh >= trial) begin
               rem_ff  <= rem_sh - trial;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh;
               root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== hw/rtl/smn_norm_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smn_norm_div
// Restoring divider for an 8-bit quotient, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smn_norm_div #(
   parameter int DEN_W = 11
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [DEN_W+smn_pkg::EDGE_W-1:0] dividend,
   input  logic [DEN_W-1:0]           divisor,
   output logic                       done,
   output logic [smn_pkg::EDGE_W-1:0] quotient
);
   import smn_pkg::*;

   localparam int NW = DEN_W + EDGE_W;
   localparam int CW = $clog2(EDGE_W + 1);

   logic [NW-1:0]     rem_ff;
   logic [NW-1:0]     dsh_ff;
   logic [EDGE_W-1:0] q_ff;
   logic [CW-1:0]     cnt_ff;
   logic              busy_ff;
   logic              done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            rem_ff  <= dividend;
            dsh_ff  <= NW'({divisor, {(EDGE_W-1){1'b0}}});
            q_ff    <= '0;
            cnt_ff  <= CW'(EDGE_W);
         end else if (busy_ff) begin
            if (rem_ff >= dsh_ff) begin
               rem_ff <= rem_ff - dsh_ff;
               q_ff   <= {q_ff[EDGE_W-2:0], 1'b1};
            end else begin
               q_ff   <= {q_ff[EDGE_W-2:0], 1'b0};
            end
            dsh_ff <= dsh_ff >> 1;
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

// ===== hw/rtl/sobel_magnitude_normalizer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_magnitude_normalizer_top
// Frame-buffered 3x3 Sobel magnitude with peak normalization on readout.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_data  (command, pixel)
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_data  (edge_value, ready_res, last)
//  csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// The last load of a frame starts a pass over the pixel memory: border
// pixels get a zero magnitude, interior pixels take nine single-port reads
// plus the bit-serial root.
// A read: magnitude RAM read, scaling, 8-step divide (skipped if peak is 0).
// Reset clears control only; the memories hold no reset value.
// req and csr stall during the frame pass and while a read is in flight.
// ----------------------------------------------------------------------------
module sobel_magnitude_normalizer_top #(
   parameter int MAX_WIDTH  = smn_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = smn_pkg::DEF_MAX_HEIGHT,
   parameter int PIXEL_BITS = smn_pkg::DEF_PIXEL_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  smn_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output smn_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [smn_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [smn_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import smn_pkg::*;

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int TOT_W  = $clog2(DEPTH + 1);
   localparam int EW     = $clog2(MAX_WIDTH + 1);
   localparam int EH     = $clog2(MAX_HEIGHT + 1);
   localparam int XW     = $clog2(MAX_WIDTH);
   localparam int YW     = $clog2(MAX_HEIGHT);
   localparam int MAG_W  = PIXEL_BITS + 3;
   localparam int G_W    = PIXEL_BITS + 4;
   localparam int AB_W   = PIXEL_BITS + 2;
   localparam int SQ_W   = 2 * AB_W;
   localparam int SUM_W  = 2 * MAG_W;
   localparam int NUM_W  = MAG_W + EDGE_W;
   localparam int W_RST  = (DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET;
   localparam int H_RST  = (DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET;
   localparam logic [PIX_IN_W-1:0] PMASK =
      (PIXEL_BITS >= PIX_IN_W) ? {PIX_IN_W{1'b1}} : PIX_IN_W'((1 << PIXEL_BITS) - 1);

   typedef enum logic [3:0] {
      S_IDLE, C_PIX, C_RD, C_ACC, C_SQR, C_SUM, C_ROOT, C_WR, R_MUL, R_DIV, R_OUT
   } state_type;

   state_type               state_ff;
   logic [EW-1:0]           ew_ff;
   logic [EH-1:0]           eh_ff;
   logic [TOT_W-1:0]        load_cnt_ff;
   logic [TOT_W-1:0]        read_cnt_ff;
   logic [MAG_W-1:0]        peak_ff;
   logic                    done_ff;
   logic [ADDR_W-1:0]       p_ff;
   logic [XW-1:0]           x_ff;
   logic [YW-1:0]           y_ff;
   logic [3:0]              k_ff;
   logic [3:0]              rdk_ff;
   logic                    rdv_ff;
   logic signed [G_W-1:0]   gx_ff;
   logic signed [G_W-1:0]   gy_ff;
   logic [SQ_W-1:0]         sqx_ff;
   logic [SQ_W-1:0]         sqy_ff;
   logic [SUM_W-1:0]        sum_ff;
   logic                    sq_start_ff;
   logic                    dv_start_ff;
   logic [NUM_W-1:0]        num_ff;
   logic [EDGE_W-1:0]       q_ff;
   logic                    last_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;

   logic [TOT_W-1:0]        total;
   logic                    req_acc;
   logic                    csr_acc;
   logic                    out_free;
   logic                    rsp_load;
   logic [TOT_W-1:0]        lc_base;
   logic [TOT_W-1:0]        lc_next;
   logic [TOT_W-1:0]        rc_next;
   logic                    border;
   logic                    last_pix;
   logic [ADDR_W-1:0]       w_addr;
   logic [ADDR_W-1:0]       nb_base;
   logic [ADDR_W-1:0]       nb_addr;
   logic                    pix_we;
   logic [PIXEL_BITS-1:0]   pix_wdata;
   logic [PIXEL_BITS-1:0]   pix_rdata;
   logic                    mag_we;
   logic [MAG_W-1:0]        mag_wdata;
   logic [MAG_W-1:0]        mag_rdata;
   logic                    sq_done;
   logic [MAG_W-1:0]        root;
   logic                    dv_done;
   logic [EDGE_W-1:0]       quot;
   logic signed [G_W-1:0]   pix_s;
   logic signed [G_W-1:0]   tx;
   logic signed [G_W-1:0]   ty;
   logic [AB_W-1:0]         ax;
   logic [AB_W-1:0]         ay;
   logic [EW-1:0]           w_in;
   logic [EH-1:0]           h_in;

   assign total    = TOT_W'(ew_ff) * TOT_W'(eh_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign csr_ready = (state_ff == S_IDLE) && !req_valid;
   assign req_acc  = req_valid && req_ready;
   assign csr_acc  = csr_valid && csr_ready;
   assign rsp_load = (req_acc && (req_data.command == CMD_READ) && !done_ff) ||
                     ((state_ff == R_OUT) && out_free);

   assign lc_base = done_ff ? '0 : load_cnt_ff;
   assign lc_next = lc_base + TOT_W'(1);
   assign rc_next = read_cnt_ff + TOT_W'(1);

   assign border   = (x_ff == '0) || (EW'(x_ff) == ew_ff - EW'(1)) ||
                     (y_ff == '0) || (EH'(y_ff) == eh_ff - EH'(1));
   assign last_pix = (TOT_W'(p_ff) + TOT_W'(1)) == total;

   assign w_addr  = ADDR_W'(ew_ff);
   always_comb begin
      unique case (k_row(k_ff))
         2'd0:    nb_base = p_ff - w_addr;
         2'd1:    nb_base = p_ff;
         default: nb_base = p_ff + w_addr;
      endcase
   end
   assign nb_addr = nb_base + ADDR_W'(k_col(k_ff)) - ADDR_W'(1);

   assign pix_we    = req_acc && (req_data.command == CMD_LOAD);
   assign pix_wdata = PIXEL_BITS'(req_data.pixel & PMASK);
   assign mag_we    = ((state_ff == C_PIX) && border) || (state_ff == C_WR);
   assign mag_wdata = (state_ff == C_WR) ? root : '0;

   assign pix_s = signed'(G_W'(pix_rdata));
   assign tx    = pix_s * G_W'(k_wx(rdk_ff));
   assign ty    = pix_s * G_W'(k_wy(rdk_ff));
   assign ax    = AB_W'(gx_ff[G_W-1] ? -gx_ff : gx_ff);
   assign ay    = AB_W'(gy_ff[G_W-1] ? -gy_ff : gy_ff);

   always_comb begin
      if (csr_wdata == '0) begin
         w_in = EW'(1);
         h_in = EH'(1);
      end else begin
         w_in = (32'(csr_wdata) > MAX_WIDTH)  ? EW'(MAX_WIDTH)  : EW'(csr_wdata);
         h_in = (32'(csr_wdata) > MAX_HEIGHT) ? EH'(MAX_HEIGHT) : EH'(csr_wdata);
      end
   end

   smn_ram #(.DEPTH(DEPTH), .DATA_W(PIXEL_BITS)) u_pix_ram (
      .clock (clock),
      .we    (pix_we),
      .waddr (lc_base[ADDR_W-1:0]),
      .wdata (pix_wdata),
      .raddr (nb_addr),
      .rdata (pix_rdata)
   );

   smn_ram #(.DEPTH(DEPTH), .DATA_W(MAG_W)) u_mag_ram (
      .clock (clock),
      .we    (mag_we),
      .waddr (p_ff),
      .wdata (mag_wdata),
      .raddr (read_cnt_ff[ADDR_W-1:0]),
      .rdata (mag_rdata)
   );

   smn_isqrt #(.ROOT_W(MAG_W)) u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start_ff),
      .value (sum_ff),
      .done  (sq_done),
      .root  (root)
   );

   smn_norm_div #(.DEN_W(MAG_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dv_start_ff),
      .dividend (num_ff),
      .divisor  (peak_ff),
      .done     (dv_done),
      .quotient (quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ew_ff        <= EW'(W_RST);
         eh_ff        <= EH'(H_RST);
         load_cnt_ff  <= '0;
         read_cnt_ff  <= '0;
         peak_ff      <= '0;
         done_ff      <= 1'b0;
         rdv_ff       <= 1'b0;
         sq_start_ff  <= 1'b0;
         dv_start_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sq_start_ff <= 1'b0;
         dv_start_ff <= 1'b0;
         rdv_ff      <= 1'b0;
         if (rsp_valid_ff && rsp_ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         if (rdv_ff) begin
            gx_ff <= gx_ff + tx;
            gy_ff <= gy_ff + ty;
         end
         if (csr_acc) begin
            if (csr_index == CSR_FRAME_WIDTH) begin
               ew_ff <= w_in;
            end
            if (csr_index == CSR_FRAME_HEIGHT) begin
               eh_ff <= h_in;
            end
            load_cnt_ff <= '0;
            read_cnt_ff <= '0;
            peak_ff     <= '0;
            done_ff     <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_acc && (req_data.command == CMD_LOAD)) begin
                  load_cnt_ff <= lc_next;
                  done_ff     <= 1'b0;
                  if (done_ff || (lc_next >= total)) begin
                     peak_ff     <= '0;
                     read_cnt_ff <= '0;
                  end
                  if (lc_next >= total) begin
                     p_ff        <= '0;
                     x_ff        <= '0;
                     y_ff        <= '0;
                     state_ff    <= C_PIX;
                  end
               end else if (req_acc) begin
                  if (!done_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_ff       <= '{edge_value: '0, ready_res: 1'b0, last: 1'b0};
                  end else begin
                     last_ff     <= (rc_next == total);
                     read_cnt_ff <= (rc_next >= total) ? '0 : rc_next;
                     state_ff    <= R_MUL;
                  end
               end
            end
            C_PIX: begin
               if (border) begin
                  if (last_pix) begin
                     done_ff  <= 1'b1;
                     state_ff <= S_IDLE;
                  end else begin
                     p_ff <= p_ff + ADDR_W'(1);
                     if (EW'(x_ff) == ew_ff - EW'(1)) begin
                        x_ff <= '0;
                        y_ff <= y_ff + YW'(1);
                     end else begin
                        x_ff <= x_ff + XW'(1);
                     end
                  end
               end else begin
                  k_ff     <= '0;
                  gx_ff    <= '0;
                  gy_ff    <= '0;
                  state_ff <= C_RD;
               end
            end
            C_RD: begin
               rdv_ff <= 1'b1;
               rdk_ff <= k_ff;
               k_ff   <= k_ff + 4'd1;
               if (k_ff == K_LAST) begin
                  state_ff <= C_ACC;
               end
            end
            C_ACC: begin
               state_ff <= C_SQR;
            end
            C_SQR: begin
               sqx_ff   <= SQ_W'(ax) * SQ_W'(ax);
               sqy_ff   <= SQ_W'(ay) * SQ_W'(ay);
               state_ff <= C_SUM;
            end
            C_SUM: begin
               sum_ff      <= SUM_W'(sqx_ff) + SUM_W'(sqy_ff);
               sq_start_ff <= 1'b1;
               state_ff    <= C_ROOT;
            end
            C_ROOT: begin
               if (sq_done) begin
                  state_ff <= C_WR;
               end
            end
            C_WR: begin
               if (root > peak_ff) begin
                  peak_ff <= root;
               end
               if (last_pix) begin
                  done_ff  <= 1'b1;
                  state_ff <= S_IDLE;
               end else begin
                  p_ff     <= p_ff + ADDR_W'(1);
                  state_ff <= C_PIX;
                  if (EW'(x_ff) == ew_ff - EW'(1)) begin
                     x_ff <= '0;
                     y_ff <= y_ff + YW'(1);
                  end else begin
                     x_ff <= x_ff + XW'(1);
                  end
               end
            end
            R_MUL: begin
               num_ff <= (NUM_W'(mag_rdata) << EDGE_W) - NUM_W'(mag_rdata);
               if (peak_ff != '0) begin
                  dv_start_ff <= 1'b1;
                  state_ff    <= R_DIV;
               end else begin
                  q_ff     <= '0;
                  state_ff <= R_OUT;
               end
            end
            R_DIV: begin
               if (dv_done) begin
                  q_ff     <= quot;
                  state_ff <= R_OUT;
               end
            end
            R_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff       <= '{edge_value: q_ff, ready_res: 1'b1, last: last_ff};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (!req_ready && !csr_ready))
      else $error("request or csr accepted while busy");

   a_peak_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == C_WR) |=> (peak_ff >= $past(peak_ff)))
      else $error("peak decreased during frame pass");

   a_done_full: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (load_cnt_ff == total))
      else $error("frame marked done before all pixels loaded");

   a_notready_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.ready_res) |-> ((rsp_ff.edge_value == '0) && !rsp_ff.last))
      else $error("result without frame carries data");

endmodule
